// ----- design/apm_pkg.sv -----
// Shared types, constants and register indexes for the audio peak meter.
`default_nettype none

package apm_pkg;

  localparam int POSITION_BITS_DEF = 10;
  localparam int POS_W = 10;
  localparam int PEAK_W = 24;
  localparam int LEVEL_W = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_FALL_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FALL_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVER_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_METER_HEIGHT = 3'd4;

  localparam logic [7:0] FALL_STEP_RST = 8'd47;
  localparam logic [6:0] HOLD_FALL_STEP_RST = 7'd56;
  localparam logic [7:0] HOLD_TICKS_RST = 8'd25;
  localparam logic [3:0] OVER_LIMIT_RST = 4'd2;
  localparam logic [POS_W-1:0] METER_HEIGHT_RST = 10'd200;

  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -15'sd12000;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 15'sd600;
  localparam logic signed [LEVEL_W-1:0] SILENCE_LEVEL = -15'sd7000;

  // centi-dB per log2 unit, Q16
  localparam logic [31:0] LOG_SCALE = 32'd39456604;
  // floor(d / 20) as (d * 3277) >> 16, exact for d below 13000
  localparam logic [25:0] D20_RECIP = 26'd3277;
  // floor(p / 4600) as (p * SCALE_RECIP) >> 38, exact for p below 2^25
  localparam logic [31:0] SCALE_RECIP = 32'd59756067;
  localparam int SCALE_ENTRIES = 381;

  typedef struct packed {
    logic              command;
    logic [PEAK_W-1:0] peak_magnitude;
  } apm_in_t;

  typedef struct packed {
    logic [POS_W-1:0] bar_position;
    logic [POS_W-1:0] hold_position;
    logic             over_led;
  } apm_out_t;

  typedef struct packed {
    logic [7:0]       fall_step;
    logic [6:0]       hold_fall_step;
    logic [7:0]       hold_ticks;
    logic [3:0]       over_limit;
    logic [POS_W-1:0] meter_height;
  } apm_cfg_t;

endpackage

`default_nettype wire

// ----- design/apm_mul.sv -----
// Shared 32x32 unsigned multiplier with registered product.
`default_nettype none

module apm_mul import apm_pkg::*; (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end

endmodule

`default_nettype wire

// ----- design/apm_eng.sv -----
// Sequencer and datapath: log conversion, ballistics, IEC scale mapping.
`default_nettype none

module apm_eng import apm_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire apm_in_t  start_data,
  input  wire apm_cfg_t cfg,
  output logic          busy,
  output logic          res_valid,
  input  wire logic     res_ready,
  output apm_out_t      res_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_NORM  = 4'd1;
  localparam logic [3:0] ST_SQ    = 4'd2;
  localparam logic [3:0] ST_SQW   = 4'd3;
  localparam logic [3:0] ST_CONV  = 4'd4;
  localparam logic [3:0] ST_CONVW = 4'd5;
  localparam logic [3:0] ST_BALL  = 4'd6;
  localparam logic [3:0] ST_ROWA  = 4'd7;
  localparam logic [3:0] ST_ROWB  = 4'd8;
  localparam logic [3:0] ST_ROWC  = 4'd9;
  localparam logic [3:0] ST_ROWD  = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  localparam int HMAX = (1 << POSITION_BITS) - 1;

  logic [3:0] state_r, state_nxt;
  logic signed [LEVEL_W-1:0] tail_r, tail_nxt, hold_r, hold_nxt;
  logic falling_r, falling_nxt;
  logic [7:0] timer_r, timer_nxt;
  logic [3:0] over_cnt_r, over_cnt_nxt;
  logic over_lit_r, over_lit_nxt;

  logic [30:0] m_r, m_nxt;
  logic [4:0] exp_r, exp_nxt;
  logic [15:0] frac_r, frac_nxt;
  logic [3:0] it_r, it_nxt;
  logic signed [LEVEL_W-1:0] lvl_r, lvl_nxt;
  logic neg_r, neg_nxt;
  logic sel_r, sel_nxt;
  logic sat_r, sat_nxt;
  logic [12:0] v_r, v_nxt;
  logic [POS_W-1:0] bar_r, bar_nxt, hpos_r, hpos_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic [POS_W-1:0] h;
  logic [7:0] t_inc, ht;
  logic t_fire;
  logic [3:0] lim, cnt_inc;
  logic [31:0] sq;
  logic signed [21:0] lq;
  logic [5:0] e_off;
  logic [20:0] mag;
  logic [63:0] rnd;
  logic [14:0] r15;
  logic signed [15:0] lvl16;
  logic signed [LEVEL_W-1:0] lvl_clip;
  logic signed [16:0] diff17;
  logic signed [LEVEL_W-1:0] tail_b, hold_b;
  logic signed [LEVEL_W-1:0] row_lvl;
  logic signed [16:0] d17;
  logic [13:0] dpos;
  logic [25:0] kp;
  logic [9:0] k;
  logic signed [14:0] ks, vs;
  logic [POS_W-1:0] q, row;

  apm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  always_comb begin
    if (32'(cfg.meter_height) > HMAX) begin
      h = POS_W'(HMAX);
    end else begin
      h = cfg.meter_height;
    end
    t_inc = timer_r + 8'd1;
    ht = (cfg.hold_ticks == 8'd0) ? 8'd1 : cfg.hold_ticks;
    t_fire = (t_inc >= ht);
    lim = (cfg.over_limit == 4'd0) ? 4'd1 : cfg.over_limit;
    if (start_data.peak_magnitude[PEAK_W-1]) begin
      cnt_inc = (over_cnt_r == 4'hF) ? 4'hF : over_cnt_r + 4'd1;
    end else begin
      cnt_inc = 4'd0;
    end

    sq = prod[61:30];

    e_off = 6'({1'b0, exp_r}) - 6'd23;
    lq = $signed({e_off, frac_r});
    mag = lq[21] ? 21'(-lq) : 21'(lq);
    rnd = prod + 64'h8000_0000;
    r15 = rnd[46:32];
    lvl16 = neg_r ? -$signed({1'b0, r15}) : $signed({1'b0, r15});
    if (lvl16 < 16'(LEVEL_MIN)) begin
      lvl_clip = LEVEL_MIN;
    end else if (lvl16 > 16'(LEVEL_MAX)) begin
      lvl_clip = LEVEL_MAX;
    end else begin
      lvl_clip = lvl16[LEVEL_W-1:0];
    end

    diff17 = 17'(tail_r) - 17'(lvl_r);
    if (diff17 > $signed({9'b0, cfg.fall_step})) begin
      tail_b = tail_r - $signed({7'b0, cfg.fall_step});
    end else begin
      tail_b = lvl_r;
    end
    if (falling_r && hold_r >= LEVEL_MIN) begin
      hold_b = hold_r - $signed({8'b0, cfg.hold_fall_step});
    end else begin
      hold_b = hold_r;
    end

    row_lvl = sel_r ? hold_r : tail_r;
    d17 = 17'(LEVEL_MAX) - 17'(row_lvl);
    dpos = d17[16] ? 14'd0 : d17[13:0];
    kp = 26'(dpos) * D20_RECIP;
    k = kp[25:16];
    ks = $signed({5'b0, k});
    if (k <= 10'd130) begin
      vs = 15'sd4600 - 15'sd20 * ks;
    end else if (k <= 10'd180) begin
      vs = 15'sd4080 - 15'sd16 * ks;
    end else if (k <= 10'd230) begin
      vs = 15'sd3360 - 15'sd12 * ks;
    end else if (k <= 10'd280) begin
      vs = 15'sd1980 - 15'sd6 * ks;
    end else begin
      vs = 15'sd1420 - 15'sd4 * ks;
    end

    q = prod[47:38];
    row = sat_r ? h : h - q;
  end

  always_comb begin
    state_nxt = state_r;
    tail_nxt = tail_r;
    hold_nxt = hold_r;
    falling_nxt = falling_r;
    timer_nxt = timer_r;
    over_cnt_nxt = over_cnt_r;
    over_lit_nxt = over_lit_r;
    m_nxt = m_r;
    exp_nxt = exp_r;
    frac_nxt = frac_r;
    it_nxt = it_r;
    lvl_nxt = lvl_r;
    neg_nxt = neg_r;
    sel_nxt = sel_r;
    sat_nxt = sat_r;
    v_nxt = v_r;
    bar_nxt = bar_r;
    hpos_nxt = hpos_r;
    mul_a = 32'd0;
    mul_b = 32'd0;
    res_valid = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          sel_nxt = 1'b0;
          if (start_data.command) begin
            tail_nxt = LEVEL_MIN;
            hold_nxt = LEVEL_MIN;
            falling_nxt = 1'b0;
            timer_nxt = 8'd0;
            over_cnt_nxt = 4'd0;
            over_lit_nxt = 1'b0;
            state_nxt = ST_ROWA;
          end else begin
            if (t_fire) begin
              falling_nxt = 1'b1;
              timer_nxt = 8'd0;
            end else begin
              timer_nxt = t_inc;
            end
            if (start_data.peak_magnitude == '0 && tail_r <= SILENCE_LEVEL) begin
              hold_nxt = LEVEL_MIN;
              over_lit_nxt = 1'b0;
              state_nxt = ST_ROWA;
            end else begin
              if (cnt_inc >= lim) begin
                over_lit_nxt = 1'b1;
                over_cnt_nxt = 4'd0;
              end else begin
                over_cnt_nxt = cnt_inc;
              end
              if (start_data.peak_magnitude == '0) begin
                lvl_nxt = LEVEL_MIN;
                state_nxt = ST_BALL;
              end else begin
                m_nxt = 31'(start_data.peak_magnitude);
                exp_nxt = 5'd30;
                state_nxt = ST_NORM;
              end
            end
          end
        end
      end
      ST_NORM: begin
        if (m_r[30]) begin
          it_nxt = 4'd0;
          state_nxt = ST_SQ;
        end else begin
          m_nxt = {m_r[29:0], 1'b0};
          exp_nxt = exp_r - 5'd1;
        end
      end
      ST_SQ: begin
        mul_a = 32'(m_r);
        mul_b = 32'(m_r);
        state_nxt = ST_SQW;
      end
      ST_SQW: begin
        if (sq[31]) begin
          m_nxt = sq[31:1];
          frac_nxt = {frac_r[14:0], 1'b1};
        end else begin
          m_nxt = sq[30:0];
          frac_nxt = {frac_r[14:0], 1'b0};
        end
        it_nxt = it_r + 4'd1;
        state_nxt = (it_r == 4'hF) ? ST_CONV : ST_SQ;
      end
      ST_CONV: begin
        mul_a = 32'(mag);
        mul_b = LOG_SCALE;
        neg_nxt = lq[21];
        state_nxt = ST_CONVW;
      end
      ST_CONVW: begin
        lvl_nxt = lvl_clip;
        state_nxt = ST_BALL;
      end
      ST_BALL: begin
        tail_nxt = tail_b;
        if (hold_b <= tail_b) begin
          hold_nxt = tail_b;
          falling_nxt = 1'b0;
          timer_nxt = 8'd0;
        end else begin
          hold_nxt = hold_b;
        end
        state_nxt = ST_ROWA;
      end
      ST_ROWA: begin
        sat_nxt = (k >= 10'(SCALE_ENTRIES)) || (vs < 0);
        v_nxt = vs[12:0];
        state_nxt = ST_ROWB;
      end
      ST_ROWB: begin
        mul_a = 32'(v_r);
        mul_b = 32'(h);
        state_nxt = ST_ROWC;
      end
      ST_ROWC: begin
        mul_a = 32'(prod[22:0]);
        mul_b = SCALE_RECIP;
        state_nxt = ST_ROWD;
      end
      ST_ROWD: begin
        if (!sel_r) begin
          bar_nxt = row;
          sel_nxt = 1'b1;
          state_nxt = ST_ROWA;
        end else begin
          hpos_nxt = row;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tail_r <= LEVEL_MIN;
      hold_r <= LEVEL_MIN;
      falling_r <= 1'b0;
      timer_r <= 8'd0;
      over_cnt_r <= 4'd0;
      over_lit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tail_r <= tail_nxt;
      hold_r <= hold_nxt;
      falling_r <= falling_nxt;
      timer_r <= timer_nxt;
      over_cnt_r <= over_cnt_nxt;
      over_lit_r <= over_lit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
    exp_r <= exp_nxt;
    frac_r <= frac_nxt;
    it_r <= it_nxt;
    lvl_r <= lvl_nxt;
    neg_r <= neg_nxt;
    sel_r <= sel_nxt;
    sat_r <= sat_nxt;
    v_r <= v_nxt;
    bar_r <= bar_nxt;
    hpos_r <= hpos_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign res_data.bar_position = bar_r;
  assign res_data.hold_position = hpos_r;
  assign res_data.over_led = over_lit_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("engine not busy after transaction start");

  a_norm_msb: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQ |-> m_r[30])
    else $error("mantissa not normalized before squaring");

  a_sq_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQW |-> prod[63:62] == 2'b00)
    else $error("square out of Q2.30 range");

  a_tail_range: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r >= LEVEL_MIN && tail_r <= LEVEL_MAX)
    else $error("bar level out of range");

  a_row_fit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROWD && !sat_r |-> prod[63:48] == '0 && q <= h)
    else $error("scale row exceeds meter height");

endmodule

`default_nettype wire

// ----- design/audio_peak_meter_ballistics.sv -----
// Top level: handshakes, configuration registers and result register.
//
// A transaction for a nonzero peak runs on the shared multiplier: one-bit
// normalization shifts, 16 squaring iterations for the log, then one
// conversion multiply and the scale rows for bar and hold. Clear commands,
// silent ticks and zero peaks skip the log. in_ready is low while an item
// is in work; a finished result waits in the output register, and the
// engine stalls only if that register is still full when the next result
// is ready.
// The configuration port is ready whenever reset is released; write it only
// while the meter is idle.
`default_nettype none

module audio_peak_meter_ballistics import apm_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire apm_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output apm_out_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  apm_cfg_t cfg_r, cfg_nxt;
  logic out_valid_r, out_valid_nxt;
  apm_out_t out_data_r;
  logic busy, res_valid, res_ready, start;
  apm_out_t res_data;

  assign cfg_ready = rst_n;
  assign start = in_valid && in_ready;
  assign in_ready = rst_n && !busy;
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_FALL_STEP:      cfg_nxt.fall_step = cfg_data[7:0];
        CFG_HOLD_FALL_STEP: cfg_nxt.hold_fall_step = cfg_data[6:0];
        CFG_HOLD_TICKS:     cfg_nxt.hold_ticks = cfg_data[7:0];
        CFG_OVER_LIMIT:     cfg_nxt.over_limit = cfg_data[3:0];
        CFG_METER_HEIGHT:   cfg_nxt.meter_height = cfg_data[POS_W-1:0];
        default: begin
        end
      endcase
    end
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fall_step <= FALL_STEP_RST;
      cfg_r.hold_fall_step <= HOLD_FALL_STEP_RST;
      cfg_r.hold_ticks <= HOLD_TICKS_RST;
      cfg_r.over_limit <= OVER_LIMIT_RST;
      cfg_r.meter_height <= METER_HEIGHT_RST;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  apm_eng #(
    .POSITION_BITS (POSITION_BITS)
  ) u_eng (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .start_data (in_data),
    .cfg        (cfg_r),
    .busy       (busy),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

endmodule

`default_nettype wire
